// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BQC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BQC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bqc_pkg.sv =====
// types, codes and fixed-point helpers of the biquad cascade filter
`timescale 1ns / 1ps
package bqc_pkg;

  localparam int unsigned SlotsPerSection = 5;
  localparam int unsigned FracBits        = 12;

  localparam logic [1:0] ADDR_ACTIVE_SECTIONS = 2'd0;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef logic signed [15:0] sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FB1,
    ST_FB2,
    ST_WN,
    ST_Y0,
    ST_Y1,
    ST_Y2,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A1W1,
    MUL_A2W2,
    MUL_B0WN,
    MUL_B1W1,
    MUL_B2W2
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     coef_wr;
    logic     load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     wn_en;
    logic     sec_next;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic last_sec;
    logic out_free;
  } stat_t;

  function automatic sample_t sat16(input logic signed [31:0] v);
    sample_t r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic sample_t qadd(input sample_t a, input sample_t b);
    logic signed [31:0] s;
    s = 32'(a) + 32'(b);
    return sat16(s);
  endfunction

  function automatic sample_t qsub(input sample_t a, input sample_t b);
    logic signed [31:0] s;
    s = 32'(a) - 32'(b);
    return sat16(s);
  endfunction

  // product shifted arithmetically, so rounding goes toward minus infinity
  function automatic sample_t qmul(input sample_t a, input sample_t b);
    logic signed [31:0] p;
    p = 32'(a) * 32'(b);
    return sat16(p >>> FracBits);
  endfunction

endpackage

// ===== sv/bqc_ram.sv =====
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bqc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bqc_ctrl.sv =====
// biquad cascade sequencer: up to one multiply per step, eight steps per section
`timescale 1ns / 1ps
module bqc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          req_type_i,
  input  bqc_pkg::stat_t stat_i,
  output bqc_pkg::cmd_t  cmd_o,
  output logic          in_stall_o
);

  bqc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bqc_pkg::ST_IDLE: begin
        if (in_valid_i && (req_type_i == bqc_pkg::REQ_SAMPLE)) begin
          state_d = stat_i.n_zero ? bqc_pkg::ST_DONE : bqc_pkg::ST_READ;
        end
      end
      bqc_pkg::ST_READ: state_d = bqc_pkg::ST_FB1;
      bqc_pkg::ST_FB1:  state_d = bqc_pkg::ST_FB2;
      bqc_pkg::ST_FB2:  state_d = bqc_pkg::ST_WN;
      bqc_pkg::ST_WN:   state_d = bqc_pkg::ST_Y0;
      bqc_pkg::ST_Y0:   state_d = bqc_pkg::ST_Y1;
      bqc_pkg::ST_Y1:   state_d = bqc_pkg::ST_Y2;
      bqc_pkg::ST_Y2:   state_d = bqc_pkg::ST_ACC;
      bqc_pkg::ST_ACC: begin
        state_d = stat_i.last_sec ? bqc_pkg::ST_DONE : bqc_pkg::ST_READ;
      end
      bqc_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = bqc_pkg::ST_IDLE;
        end
      end
      default: state_d = bqc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = bqc_pkg::MUL_NONE;
    cmd_o.acc_op   = bqc_pkg::ACC_HOLD;
    in_stall_o     = 1'b1;
    case (state_q)
      bqc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == bqc_pkg::REQ_COEF) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      bqc_pkg::ST_FB1: cmd_o.mul_sel = bqc_pkg::MUL_A1W1;
      bqc_pkg::ST_FB2: begin
        cmd_o.mul_sel = bqc_pkg::MUL_A2W2;
        cmd_o.acc_op  = bqc_pkg::ACC_LOAD;
      end
      bqc_pkg::ST_WN: cmd_o.wn_en = 1'b1;
      bqc_pkg::ST_Y0: cmd_o.mul_sel = bqc_pkg::MUL_B0WN;
      bqc_pkg::ST_Y1: begin
        cmd_o.mul_sel = bqc_pkg::MUL_B1W1;
        cmd_o.acc_op  = bqc_pkg::ACC_LOAD;
      end
      bqc_pkg::ST_Y2: begin
        cmd_o.mul_sel = bqc_pkg::MUL_B2W2;
        cmd_o.acc_op  = bqc_pkg::ACC_ADD;
      end
      bqc_pkg::ST_ACC: cmd_o.sec_next = 1'b1;
      bqc_pkg::ST_DONE: cmd_o.out_load = stat_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/bqc_datapath.sv =====
// coefficient memories, delay lines, shared multiplier and output register
`timescale 1ns / 1ps
module bqc_datapath #(
  parameter int unsigned MAX_SECTIONS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bqc_pkg::cmd_t        cmd_i,
  output bqc_pkg::stat_t       stat_o,
  input  logic [3:0]           active_sections_i,
  input  bqc_pkg::sample_t     sample_in_i,
  input  logic                 last_sample_i,
  input  logic [2:0]           coef_section_i,
  input  logic [2:0]           coef_slot_i,
  input  bqc_pkg::sample_t     coef_value_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output bqc_pkg::sample_t     sample_out_o
);

  localparam int unsigned SecW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SECTIONS + 1);

  logic [CntW-1:0]  sec_q, n_eff;
  logic [SecW-1:0]  sec_idx, coef_waddr;
  logic [7:0]       coef_sec_ext;
  logic             coef_ok;

  bqc_pkg::sample_t coef [bqc_pkg::SlotsPerSection];
  bqc_pkg::sample_t d1_q [MAX_SECTIONS];
  bqc_pkg::sample_t d2_q [MAX_SECTIONS];
  bqc_pkg::sample_t w1, w2;
  bqc_pkg::sample_t x_q, wn_q, acc_q, prod_q, out_q;
  bqc_pkg::sample_t op_a, op_b, acc_sum;
  logic             last_q, out_valid_q;

  assign sec_idx      = sec_q[SecW-1:0];
  assign coef_sec_ext = 8'(coef_section_i);
  assign coef_waddr   = coef_sec_ext[SecW-1:0];
  assign coef_ok      = (32'(coef_section_i) < 32'(MAX_SECTIONS));

  for (genvar g = 0; g < bqc_pkg::SlotsPerSection; g++) begin : g_coef
    bqc_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SECTIONS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.coef_wr && coef_ok && (coef_slot_i == 3'(g))),
      .waddr_i (coef_waddr),
      .wdata_i (coef_value_i),
      .raddr_i (sec_idx),
      .rdata_o (coef[g])
    );
  end

  always_comb begin
    if (32'(active_sections_i) > 32'(MAX_SECTIONS)) begin
      n_eff = CntW'(MAX_SECTIONS);
    end else begin
      n_eff = CntW'(active_sections_i);
    end
  end

  assign w1      = d1_q[sec_idx];
  assign w2      = d2_q[sec_idx];
  assign acc_sum = bqc_pkg::qadd(acc_q, prod_q);

  assign stat_o.n_zero   = (active_sections_i == 4'd0);
  assign stat_o.last_sec = ((sec_q + CntW'(1)) == n_eff);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      bqc_pkg::MUL_A1W1: begin
        op_a = coef[bqc_pkg::SLOT_A1];
        op_b = w1;
      end
      bqc_pkg::MUL_A2W2: begin
        op_a = coef[bqc_pkg::SLOT_A2];
        op_b = w2;
      end
      bqc_pkg::MUL_B0WN: begin
        op_a = coef[bqc_pkg::SLOT_B0];
        op_b = wn_q;
      end
      bqc_pkg::MUL_B1W1: begin
        op_a = coef[bqc_pkg::SLOT_B1];
        op_b = w1;
      end
      bqc_pkg::MUL_B2W2: begin
        op_a = coef[bqc_pkg::SLOT_B2];
        op_b = w2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != bqc_pkg::MUL_NONE) begin
      prod_q <= bqc_pkg::qmul(op_a, op_b);
    end
    case (cmd_i.acc_op)
      bqc_pkg::ACC_LOAD: acc_q <= prod_q;
      bqc_pkg::ACC_ADD:  acc_q <= acc_sum;
      default: begin
      end
    endcase
    if (cmd_i.wn_en) begin
      wn_q <= bqc_pkg::qsub(x_q, acc_sum);
    end
    if (cmd_i.load) begin
      x_q    <= sample_in_i;
      last_q <= last_sample_i;
    end else if (cmd_i.sec_next) begin
      x_q <= acc_sum;
    end
    if (cmd_i.out_load) begin
      out_q <= x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= '0;
    end else if (cmd_i.load) begin
      sec_q <= '0;
    end else if (cmd_i.sec_next) begin
      sec_q <= sec_q + CntW'(1);
    end
  end

  // delay lines, cleared at once after the last sample of a block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (cmd_i.out_load && last_q) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (cmd_i.sec_next) begin
      d2_q[sec_idx] <= w1;
      d1_q[sec_idx] <= wn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// ===== sv/biquad_cascade_filter_unit.sv =====
// top level of the cascaded direct-form-two biquad filter
// usage:
//   input channel (in_valid_i / in_stall_o) carries one request per transaction:
//   a coefficient write (req_type_i = 1) or a sample to filter (req_type_i = 0)
//   output channel (out_valid_o / out_stall_i) carries one filtered sample
//   per sample transaction, none per coefficient write
//   active_sections is set through the apb port at address 0
// sequencing:
//   a coefficient write is taken in idle, the next request is taken right after
//   a sample runs the eight steps of each active section, then the done state
//   loads the output register, out_valid_o rises and idle takes the next request
//   the single shared multiplier sets the steps: coefficient read, five products,
//   feedback subtract and delay update make eight steps per section
//   with zero active sections the sample goes straight to done and shows unchanged
// reset:
//   active_sections returns to 1, all delays clear, coefficients are undefined
//   until written
// stall:
//   the output register holds a result while out_stall_i is high; requests are
//   still taken until the next finished sample needs the output register
`timescale 1ns / 1ps
module biquad_cascade_filter_unit #(
  parameter int unsigned MAX_SECTIONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic signed [15:0]  sample_in_i,
  input  logic                last_sample_i,
  input  logic [2:0]          coef_section_i,
  input  logic [2:0]          coef_slot_i,
  input  logic signed [15:0]  coef_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  sample_out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  bqc_pkg::cmd_t  cmd;
  bqc_pkg::stat_t stat;
  logic [3:0]     active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 4'd1;
    end else if (psel && penable && pwrite && (paddr == bqc_pkg::ADDR_ACTIVE_SECTIONS)) begin
      active_q <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {28'd0, active_q};

  bqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  bqc_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .active_sections_i (active_q),
    .sample_in_i       (sample_in_i),
    .last_sample_i     (last_sample_i),
    .coef_section_i    (coef_section_i),
    .coef_slot_i       (coef_slot_i),
    .coef_value_i      (coef_value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .sample_out_o      (sample_out_o)
  );

endmodule

// ===== sv/bqc_checker.sv =====
// port-level checks of the biquad cascade filter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bqc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] sample_out_o
);

  logic coef_acc, smp_acc;

  assign coef_acc = in_valid_i && !in_stall_o && (req_type_i == bqc_pkg::REQ_COEF);
  assign smp_acc  = in_valid_i && !in_stall_o && (req_type_i == bqc_pkg::REQ_SAMPLE);

  `BQC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(sample_out_o))
  `BQC_ASSERT_NXT(a_coef_no_stall, clk_i, rst_ni, coef_acc, !in_stall_o)
  `BQC_ASSERT_NXT(a_sample_busy, clk_i, rst_ni, smp_acc, in_stall_o)
  `BQC_ASSERT_IMP(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind biquad_cascade_filter_unit bqc_checker u_bqc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o)
);
